// ===== rtl/core/i2cmbe_pkg.sv =====
// Shared types and constants for the I2C master bit engine.
`timescale 1ns / 1ps
`default_nettype none
package i2cmbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
  localparam int DELAY_W       = 16;
  localparam int FUNC_W        = 3;

  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  // result word bit positions
  localparam int OUT_SCL_BIT  = 0;
  localparam int OUT_SDA_BIT  = 1;
  localparam int OUT_BUSY_BIT = 2;
  localparam int OUT_DONE_BIT = 3;
  localparam int OUT_RX_LSB   = 4;
  localparam int OUT_ACK_BIT  = OUT_RX_LSB + BITS_PER_BYTE;

  localparam logic [DELAY_W-1:0] PHASE_DELAY_RESET = 16'd72;

  typedef enum logic [FUNC_W-1:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/i2c_master_bit_engine.sv =====
// I2C master bit engine: timed SCL/SDA sequencer, one input word per clock tick while the result register is free.
`timescale 1ns / 1ps
`default_nettype none
// Each input word is one bus tick and carries an optional command (start, stop,
// write byte, read byte, send ack), the byte to send and the sampled SDA level.
// Every accepted word yields exactly one result word with the SCL/SDA levels,
// busy, done, the last received byte and the last ACK bit. A word is taken
// every cycle while the result register is empty or being drained; its result
// is shown in the following cycle from that single output register. Each bus phase is
// held for phase_delay_ticks ticks (0 acts as 1); commands arriving while busy
// are ignored.
module i2c_master_bit_engine (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // [2:0] func, [10:3] tx_byte, [11] sda_in, [15:12] zero
  input  wire  [i2cmbe_pkg::IN_W-1:0]      in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_bit, [15:13] zero
  output logic [i2cmbe_pkg::OUT_W-1:0]     out_tdata,
  input  wire                              cfg_we,
  input  wire  [i2cmbe_pkg::DELAY_W-1:0]   cfg_wdata
);

  localparam int BPB = i2cmbe_pkg::BITS_PER_BYTE;
  localparam int BCW = i2cmbe_pkg::BIT_CNT_W;
  localparam int DW  = i2cmbe_pkg::DELAY_W;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2,
    PH_THREE = 2'd3
  } phase_t;

  phase_t                  phase_r,   phase_nxt;
  i2cmbe_pkg::cmd_t        cmd_r,     cmd_nxt;
  logic [BCW-1:0]          bit_cnt_r, bit_cnt_nxt;
  logic [BPB-1:0]          shift_r,   shift_nxt;
  logic [DW-1:0]           delay_r,   delay_nxt;
  logic                    scl_r,     scl_nxt;
  logic                    sda_r,     sda_nxt;
  logic                    ack_r,     ack_nxt;
  logic [BPB-1:0]          rx_r,      rx_nxt;
  logic [DW-1:0]           pdt_r;
  logic                    out_valid_r;
  logic [i2cmbe_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic [i2cmbe_pkg::FUNC_W-1:0] func;
  logic [BPB-1:0]          tx_byte;
  logic                    sda_in;
  logic                    accept;
  logic                    done;
  logic                    fin;
  logic                    drive;

  assign func    = in_tdata[i2cmbe_pkg::FUNC_W-1:0];
  assign tx_byte = in_tdata[i2cmbe_pkg::FUNC_W +: BPB];
  assign sda_in  = in_tdata[i2cmbe_pkg::FUNC_W + BPB];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    delay_nxt   = delay_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    ack_nxt     = ack_r;
    rx_nxt      = rx_r;
    done        = 1'b0;
    fin         = 1'b0;
    drive       = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (func >= i2cmbe_pkg::CMD_START && func <= i2cmbe_pkg::CMD_ACK) begin
        cmd_nxt     = i2cmbe_pkg::cmd_t'(func);
        bit_cnt_nxt = '0;
        shift_nxt   = (func == i2cmbe_pkg::CMD_WRITE) ? tx_byte : '0;
        phase_nxt   = PH_ONE;
        drive       = 1'b1;
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - 1'b1;
    end else begin
      // end of the current phase
      case (cmd_r)
        i2cmbe_pkg::CMD_START, i2cmbe_pkg::CMD_STOP: begin
          if (phase_r == PH_ONE) phase_nxt = PH_TWO;
          else fin = 1'b1;
        end
        i2cmbe_pkg::CMD_WRITE: begin
          if (bit_cnt_r < BCW'(BPB)) begin
            if (phase_r == PH_ONE) phase_nxt = PH_TWO;
            else if (phase_r == PH_TWO) phase_nxt = PH_THREE;
            else begin
              shift_nxt   = {shift_r[BPB-2:0], 1'b0};
              bit_cnt_nxt = bit_cnt_r + 1'b1;
              phase_nxt   = PH_ONE;
            end
          end else if (phase_r == PH_ONE) begin
            ack_nxt   = sda_in;
            phase_nxt = PH_TWO;
          end else begin
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::CMD_READ: begin
          if (phase_r == PH_ONE) begin
            shift_nxt = {shift_r[BPB-2:0], sda_in};
            phase_nxt = PH_TWO;
          end else begin
            bit_cnt_nxt = bit_cnt_r + 1'b1;
            if (bit_cnt_nxt >= BCW'(BPB)) begin
              rx_nxt = shift_r;
              fin    = 1'b1;
            end else begin
              phase_nxt = PH_ONE;
            end
          end
        end
        i2cmbe_pkg::CMD_ACK: begin
          if (phase_r == PH_ONE) phase_nxt = PH_TWO;
          else if (phase_r == PH_TWO) phase_nxt = PH_THREE;
          else begin
            sda_nxt = 1'b1;
            fin     = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase

      if (fin) begin
        phase_nxt   = PH_IDLE;
        cmd_nxt     = i2cmbe_pkg::CMD_NONE;
        bit_cnt_nxt = '0;
        delay_nxt   = '0;
        done        = 1'b1;
      end else begin
        drive = 1'b1;
      end
    end

    // levels of the phase that begins now
    if (drive) begin
      case (cmd_nxt)
        i2cmbe_pkg::CMD_START: begin
          if (phase_nxt == PH_ONE) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_STOP: begin
          if (phase_nxt == PH_ONE) begin
            sda_nxt = 1'b0;
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        i2cmbe_pkg::CMD_WRITE: begin
          if (bit_cnt_nxt < BCW'(BPB)) begin
            if (phase_nxt == PH_ONE) begin
              scl_nxt = 1'b0;
              sda_nxt = shift_nxt[BPB-1];
            end else if (phase_nxt == PH_TWO) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
              // release SDA after the last data bit, ahead of the ACK slot
              if (bit_cnt_nxt == BCW'(BPB - 1)) sda_nxt = 1'b1;
            end
          end else if (phase_nxt == PH_ONE) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_READ: begin
          sda_nxt = 1'b1;
          scl_nxt = (phase_nxt == PH_ONE);
        end
        i2cmbe_pkg::CMD_ACK: begin
          if (phase_nxt == PH_ONE) sda_nxt = 1'b0;
          else if (phase_nxt == PH_TWO) scl_nxt = 1'b1;
          else scl_nxt = 1'b0;
        end
        default: ;
      endcase
      delay_nxt = (pdt_r == '0) ? '0 : pdt_r - 1'b1;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[i2cmbe_pkg::OUT_SCL_BIT]             = scl_nxt;
    out_data_nxt[i2cmbe_pkg::OUT_SDA_BIT]             = sda_nxt;
    out_data_nxt[i2cmbe_pkg::OUT_BUSY_BIT]            = (phase_nxt != PH_IDLE);
    out_data_nxt[i2cmbe_pkg::OUT_DONE_BIT]            = done;
    out_data_nxt[i2cmbe_pkg::OUT_RX_LSB +: BPB]       = rx_nxt;
    out_data_nxt[i2cmbe_pkg::OUT_ACK_BIT]             = ack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cmd_r       <= i2cmbe_pkg::CMD_NONE;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      delay_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b1;
      rx_r        <= '0;
      pdt_r       <= i2cmbe_pkg::PHASE_DELAY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) pdt_r <= cfg_wdata;
      if (accept) begin
        phase_r   <= phase_nxt;
        cmd_r     <= cmd_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        delay_r   <= delay_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        ack_r     <= ack_nxt;
        rx_r      <= rx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/i2cmbe_checker.sv =====
// Port-level checker for the I2C master bit engine and its bind.
`timescale 1ns / 1ps
`default_nettype none
module i2cmbe_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tvalid,
  input wire                          in_tready,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [i2cmbe_pkg::OUT_W-1:0]  out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // every accepted word produces a result word next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word gave no result");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // the done word always shows the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[i2cmbe_pkg::OUT_DONE_BIT]
      |-> !out_tdata[i2cmbe_pkg::OUT_BUSY_BIT])
    else $error("done reported while busy");

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_i2cmbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
